// File: sv/index_allocator_assert.svh
// Assertion macros for the index allocator RTL.
// Included by ia_datapath, which checks its own logic; needs no package.
`ifndef INDEX_ALLOCATOR_ASSERT_SVH
`define INDEX_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted
`define IA_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("index_allocator: same-cycle check failed");

// Next-cycle implication, held off while reset is asserted
`define IA_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("index_allocator: next-cycle check failed");

`endif

// File: sv/ia_pkg.sv
// Shared types and constants of the index allocator.
// No dependencies; used by the interfaces, controller, datapath and top level.
`timescale 1ns / 1ps

package ia_pkg;

	localparam int ID_W  = 8;
	localparam int CNT_W = 9;

	// transaction kind codes
	localparam logic KIND_RELEASE = 1'b1;

	// reset value of the capacity register
	localparam logic [CNT_W-1:0] CAPACITY_RST = 9'd256;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACQ_TAKE,
		ST_SCAN,
		ST_SWAP_WR1,
		ST_SWAP_WR2,
		ST_RESULT
	} ia_state_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_HELD,
		RD_SCAN,
		RD_TOP
	} ia_rd_sel_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_MINT,
		WR_MATCH,
		WR_TOP
	} ia_wr_sel_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} ia_cnt_op_t;

	typedef enum logic [2:0] {
		RES_HOLD,
		RES_FAIL,
		RES_MINT,
		RES_REUSE,
		RES_FREED
	} ia_res_op_t;

	// controller -> datapath
	typedef struct packed {
		logic       capture_req;
		logic       scan_start;
		logic       scan_step;
		logic       match_save;
		ia_rd_sel_t rd_sel;
		ia_wr_sel_t wr_sel;
		ia_cnt_op_t held_op;
		logic       minted_inc;
		ia_res_op_t res_op;
		logic       rsp_load;
	} ia_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic can_reuse;
		logic can_mint;
		logic scan_more;
		logic cmp_pending;
		logic hit;
		logic rsp_free;
	} ia_stat_t;

endpackage

// File: sv/ia_if.sv
// Handshake channels of the index allocator: request and response.
// Depends on ia_pkg for the field widths.
`timescale 1ns / 1ps

interface ia_req_if import ia_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            kind;
	logic [ID_W-1:0] index;

	modport source (output valid, output kind, output index, input ready);
	modport sink   (input valid, input kind, input index, output ready);
endinterface

interface ia_rsp_if import ia_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ID_W-1:0]  granted_index;
	logic             ok;
	logic [CNT_W-1:0] active_count;
	logic [CNT_W-1:0] acquired_count;

	modport source (output valid, output granted_index, output ok,
		output active_count, output acquired_count, input ready);
	modport sink   (input valid, input granted_index, input ok,
		input active_count, input acquired_count, output ready);
endinterface

// File: sv/ia_ctrl.sv
// Sequencing state machine of the index allocator.
// Depends on ia_pkg; drives the datapath through ia_cmd_t, watches ia_stat_t.
`timescale 1ns / 1ps

module ia_ctrl import ia_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_kind,
	output logic     req_ready,
	input  ia_stat_t stat,
	output ia_cmd_t  cmd
);

	ia_state_t state_q;
	ia_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture_req = 1'b1;
					if (req_kind == KIND_RELEASE) begin
						cmd.scan_start = 1'b1;
						state_d        = ST_SCAN;
					end else if (stat.can_reuse) begin
						cmd.rd_sel = RD_HELD;
						state_d    = ST_ACQ_TAKE;
					end else if (stat.can_mint) begin
						cmd.wr_sel     = WR_MINT;
						cmd.held_op    = CNT_INC;
						cmd.minted_inc = 1'b1;
						cmd.res_op     = RES_MINT;
						state_d        = ST_RESULT;
					end else begin
						cmd.res_op = RES_FAIL;
						state_d    = ST_RESULT;
					end
				end
			end
			ST_ACQ_TAKE: begin
				// released id is now in the read register
				cmd.res_op  = RES_REUSE;
				cmd.held_op = CNT_INC;
				state_d     = ST_RESULT;
			end
			ST_SCAN: begin
				priority if (stat.hit) begin
					cmd.match_save = 1'b1;
					cmd.rd_sel     = RD_TOP;
					state_d        = ST_SWAP_WR1;
				end else if (!stat.scan_more && !stat.cmp_pending) begin
					cmd.res_op = RES_FAIL;
					state_d    = ST_RESULT;
				end else begin
					cmd.scan_step = 1'b1;
					cmd.rd_sel    = RD_SCAN;
				end
			end
			ST_SWAP_WR1: begin
				cmd.wr_sel = WR_MATCH;
				state_d    = ST_SWAP_WR2;
			end
			ST_SWAP_WR2: begin
				cmd.wr_sel  = WR_TOP;
				cmd.held_op = CNT_DEC;
				cmd.res_op  = RES_FREED;
				state_d     = ST_RESULT;
			end
			ST_RESULT: begin
				if (stat.rsp_free) begin
					cmd.rsp_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: sv/ia_datapath.sv
// Datapath of the index allocator: id table, counts, scan pipe, result register.
// Depends on ia_pkg, ia_if and index_allocator_assert.svh.
`timescale 1ns / 1ps
`include "index_allocator_assert.svh"

module ia_datapath import ia_pkg::*; #(
	parameter int MAX_INDICES = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  logic [ID_W-1:0]  req_index,
	input  ia_cmd_t          cmd,
	output ia_stat_t         stat,
	ia_rsp_if.source         rsp
);

	localparam int AW = (MAX_INDICES > 1) ? $clog2(MAX_INDICES) : 1;
	localparam int CW = $clog2(MAX_INDICES + 1);
	localparam int XW = (CW > CNT_W) ? CW : CNT_W;

	logic [ID_W-1:0]  table_mem [MAX_INDICES];
	logic [ID_W-1:0]  rdata_q;

	logic [CNT_W-1:0] capacity_q;
	logic [CW-1:0]    held_q;
	logic [CW-1:0]    minted_q;
	logic [ID_W-1:0]  want_q;
	logic [CW-1:0]    scan_q;
	logic [AW-1:0]    cmp_addr_s1;
	logic             cmp_vld_s1;
	logic [AW-1:0]    match_q;
	logic [ID_W-1:0]  res_granted_q;
	logic             res_ok_q;

	logic [ID_W-1:0]  granted_q;
	logic             ok_q;
	logic [CNT_W-1:0] active_q;
	logic [CNT_W-1:0] acquired_q;
	logic             rsp_valid_q;

	logic [AW-1:0]    top_addr;
	logic [AW-1:0]    rd_addr;
	logic             rd_en;
	logic [AW-1:0]    wr_addr;
	logic [ID_W-1:0]  wr_data;
	logic             wr_en;
	logic [XW-1:0]    minted_x;

	assign top_addr = AW'(held_q - CW'(1));
	assign minted_x = XW'(minted_q);

	// status towards the controller
	always_comb begin
		stat.can_reuse   = held_q < minted_q;
		stat.can_mint    = (minted_x < XW'(capacity_q)) && (minted_x < XW'(MAX_INDICES));
		stat.scan_more   = scan_q < held_q;
		stat.cmp_pending = cmp_vld_s1;
		stat.hit         = cmp_vld_s1 && (rdata_q == want_q);
		stat.rsp_free    = !rsp_valid_q || rsp.ready;
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RST;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// table port selection
	always_comb begin
		rd_en   = 1'b1;
		rd_addr = held_q[AW-1:0];
		unique case (cmd.rd_sel)
			RD_NONE: rd_en = 1'b0;
			RD_HELD: rd_addr = AW'(held_q);
			RD_SCAN: rd_addr = AW'(scan_q);
			RD_TOP:  rd_addr = top_addr;
			default: rd_en = 1'b0;
		endcase
	end

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = AW'(held_q);
		wr_data = ID_W'(minted_q);
		unique case (cmd.wr_sel)
			WR_NONE: wr_en = 1'b0;
			WR_MINT: begin
				wr_addr = AW'(held_q);
				wr_data = ID_W'(minted_q);
			end
			WR_MATCH: begin
				wr_addr = match_q;
				wr_data = rdata_q;
			end
			WR_TOP: begin
				wr_addr = top_addr;
				wr_data = want_q;
			end
			default: wr_en = 1'b0;
		endcase
	end

	// id table, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= table_mem[rd_addr];
		end
	end

	// counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '0;
			minted_q <= '0;
		end else begin
			unique case (cmd.held_op)
				CNT_HOLD: held_q <= held_q;
				CNT_INC:  held_q <= held_q + CW'(1);
				CNT_DEC:  held_q <= held_q - CW'(1);
				default:  held_q <= held_q;
			endcase
			if (cmd.minted_inc) begin
				minted_q <= minted_q + CW'(1);
			end
		end
	end

	// scan pipe: address issue, then compare in the cycle after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_s1 <= 1'b0;
		end else if (cmd.scan_start || cmd.match_save) begin
			cmp_vld_s1 <= 1'b0;
		end else if (cmd.scan_step) begin
			cmp_vld_s1 <= stat.scan_more;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture_req) begin
			want_q <= req_index;
		end
		if (cmd.scan_start) begin
			scan_q <= '0;
		end else if (cmd.scan_step && stat.scan_more) begin
			scan_q <= scan_q + CW'(1);
		end
		if (cmd.scan_step) begin
			cmp_addr_s1 <= AW'(scan_q);
		end
		if (cmd.match_save) begin
			match_q <= cmp_addr_s1;
		end
	end

	// staged result of the current transaction
	always_ff @(posedge clk) begin
		unique case (cmd.res_op)
			RES_HOLD: begin
				res_ok_q <= res_ok_q;
			end
			RES_FAIL: begin
				res_granted_q <= '0;
				res_ok_q      <= 1'b0;
			end
			RES_MINT: begin
				res_granted_q <= ID_W'(minted_q);
				res_ok_q      <= 1'b1;
			end
			RES_REUSE: begin
				res_granted_q <= rdata_q;
				res_ok_q      <= 1'b1;
			end
			RES_FREED: begin
				res_granted_q <= '0;
				res_ok_q      <= 1'b1;
			end
			default: begin
				res_ok_q <= res_ok_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rsp_load) begin
			granted_q  <= res_granted_q;
			ok_q       <= res_ok_q;
			active_q   <= CNT_W'(minted_q);
			acquired_q <= CNT_W'(held_q);
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.granted_index  = granted_q;
	assign rsp.ok             = ok_q;
	assign rsp.active_count   = active_q;
	assign rsp.acquired_count = acquired_q;

	// checks
	`IA_ASSERT_IMP(a_held_le_minted, clk, arst_n, 1'b1, held_q <= minted_q)
	`IA_ASSERT_IMP(a_mint_allowed, clk, arst_n, cmd.wr_sel == WR_MINT, stat.can_mint)
	`IA_ASSERT_IMP(a_dec_nonzero, clk, arst_n, cmd.held_op == CNT_DEC, held_q != '0)
	`IA_ASSERT_NXT(a_mint_step, clk, arst_n, cmd.minted_inc,
		minted_q == $past(minted_q) + CW'(1))

endmodule

// File: sv/index_allocator.sv
// Top level of the index allocator: request/response channels, capacity register.
// Depends on ia_pkg, ia_if, ia_ctrl and ia_datapath.
//
//   channel   | direction | handshake     | payload
//   req       | in        | valid / ready | kind, index
//   rsp       | out       | valid / ready | granted_index, ok, active_count, acquired_count
//   cfg       | in        | cfg_we only   | cfg_wdata (capacity)
//
// One transaction at a time; req.ready is high only while the controller is idle.
// Acquire: a minted id or a failure goes straight to the result; a released id is
// reused through ST_ACQ_TAKE (one registered table read). Release: a scan of
// one table entry per cycle over the held entries, then a two-write swap.
// A finished result waits in the output register while the next request is taken.
// arst_n clears the counts, the capacity (to 256) and the handshake state; the
// table itself is not cleared.
`timescale 1ns / 1ps

module index_allocator import ia_pkg::*; #(
	parameter int MAX_INDICES = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	ia_req_if.sink           req,
	ia_rsp_if.source         rsp,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	ia_cmd_t  cmd;
	ia_stat_t stat;
	logic     ready;

	assign req.ready = ready;

	// sequencing
	ia_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_kind  (req.kind),
		.req_ready (ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// table, counts and result
	ia_datapath #(
		.MAX_INDICES (MAX_INDICES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_index (req.index),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp)
	);

endmodule

// File: bench/index_allocator_checker.sv
// Response checker for the index allocator: watches request, response and capacity ports.
// Keeps its own id table and counts, predicts every response and compares it.
// Depends on ia_pkg.
`timescale 1ns / 1ps

module index_allocator_checker import ia_pkg::*; #(
	parameter int MAX_INDICES = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_ready,
	input  logic             req_kind,
	input  logic [ID_W-1:0]  req_index,
	input  logic             rsp_valid,
	input  logic             rsp_ready,
	input  logic [ID_W-1:0]  rsp_granted_index,
	input  logic             rsp_ok,
	input  logic [CNT_W-1:0] rsp_active_count,
	input  logic [CNT_W-1:0] rsp_acquired_count,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	output int               fail_count,
	output int               awaited_count,
	output int               checked_count,
	output int               ok_count,
	output int               peak_held
);

	typedef struct packed {
		logic [ID_W-1:0]  granted_index;
		logic             ok;
		logic [CNT_W-1:0] active_count;
		logic [CNT_W-1:0] acquired_count;
	} alloc_rsp_t;

	// shadow of the allocator state
	logic [ID_W-1:0]  id_slots [MAX_INDICES];
	logic [CNT_W-1:0] capacity_reg;
	int               minted;
	int               held;

	alloc_rsp_t awaited_rsp [$];
	int         mismatches;
	int         checked;
	int         succeeded;
	int         held_peak;

	// Works out the response to one request and updates the shadow state
	function automatic alloc_rsp_t serve_request(logic kind, logic [ID_W-1:0] want);
		alloc_rsp_t      r;
		int              limit;
		int              top;
		int              k;
		logic            found;
		logic [ID_W-1:0] moved;
		r = '0;
		found = 1'b0;
		limit = (int'(capacity_reg) > MAX_INDICES) ? MAX_INDICES : int'(capacity_reg);
		if (kind != KIND_RELEASE) begin
			if (held < minted) begin
				// most recently released id is handed out again
				r.granted_index = id_slots[held];
				held++;
				r.ok = 1'b1;
			end else if (minted < limit) begin
				// mint a fresh id
				r.granted_index = ID_W'(minted);
				id_slots[held] = r.granted_index;
				minted++;
				held++;
				r.ok = 1'b1;
			end
		end else begin
			// linear search of the held part, first match swapped with the top entry
			top = held;
			for (k = 0; k < top; k++) begin
				if (!found && id_slots[k] == want) begin
					moved = id_slots[top-1];
					id_slots[top-1] = id_slots[k];
					id_slots[k] = moved;
					held = top - 1;
					found = 1'b1;
				end
			end
			r.ok = found;
		end
		r.active_count = CNT_W'(minted);
		r.acquired_count = CNT_W'(held);
		return r;
	endfunction

	task automatic check_field(string field, logic [CNT_W-1:0] want_v, logic [CNT_W-1:0] got_v);
		if (got_v !== want_v) begin
			mismatches++;
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want_v,
				got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		alloc_rsp_t want_rsp;
		if (!arst_n) begin
			foreach (id_slots[i])
				id_slots[i] = '0;
			capacity_reg = CAPACITY_RST;
			minted = 0;
			held = 0;
			awaited_rsp.delete();
			mismatches = 0;
			checked = 0;
			succeeded = 0;
			held_peak = 0;
		end else begin
			if (cfg_we)
				capacity_reg = cfg_wdata;

			// response side first: it always belongs to an earlier request
			if (rsp_valid && rsp_ready) begin
				if (awaited_rsp.size() == 0) begin
					mismatches++;
					$display("%0t ns: response with none expected, got index %0d ok %0d",
						$time, rsp_granted_index, rsp_ok);
				end else begin
					want_rsp = awaited_rsp.pop_front();
					check_field("granted_index", CNT_W'(want_rsp.granted_index),
						CNT_W'(rsp_granted_index));
					check_field("ok", CNT_W'(want_rsp.ok), CNT_W'(rsp_ok));
					check_field("active_count", want_rsp.active_count, rsp_active_count);
					check_field("acquired_count", want_rsp.acquired_count, rsp_acquired_count);
					checked++;
					if (want_rsp.ok)
						succeeded++;
				end
			end

			if (req_valid && req_ready)
				awaited_rsp.push_back(serve_request(req_kind, req_index));
			if (held > held_peak)
				held_peak = held;
		end
		fail_count <= mismatches;
		awaited_count <= awaited_rsp.size();
		checked_count <= checked;
		ok_count <= succeeded;
		peak_held <= held_peak;
	end

endmodule

// File: bench/tb_index_allocator.sv
// Top of the index allocator testbench: clock, reset, request and response traffic.
// Depends on ia_pkg, ia_if, index_allocator and index_allocator_checker.
`timescale 1ns / 1ps

module tb_index_allocator;
	import ia_pkg::*;

	localparam logic KIND_ACQUIRE = ~KIND_RELEASE;
	localparam int   CYCLE_LIMIT  = 1_500_000;
	localparam int   MAX_WAIT     = 12;
	localparam int   LONG_HOLD    = 400;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	ia_req_if req ();
	ia_rsp_if rsp ();

	int fail_count;
	int awaited_count;
	int checked_count;
	int ok_count;
	int peak_held;
	int cycle_count;
	int sent;
	int cap_writes;
	bit quiet;
	bit hold_request;

	index_allocator #(.MAX_INDICES(256)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	index_allocator_checker #(.MAX_INDICES(256)) u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.req_valid          (req.valid),
		.req_ready          (req.ready),
		.req_kind           (req.kind),
		.req_index          (req.index),
		.rsp_valid          (rsp.valid),
		.rsp_ready          (rsp.ready),
		.rsp_granted_index  (rsp.granted_index),
		.rsp_ok             (rsp.ok),
		.rsp_active_count   (rsp.active_count),
		.rsp_acquired_count (rsp.acquired_count),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.fail_count         (fail_count),
		.awaited_count      (awaited_count),
		.checked_count      (checked_count),
		.ok_count           (ok_count),
		.peak_held          (peak_held)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILED: results differ");
		$finish;
	end

	// response side: random stall per transaction, one long hold when asked
	initial begin : response_sink
		int stall;
		rsp.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				stall = LONG_HOLD;
				hold_request = 1'b0;
			end else begin
				stall = quiet ? 0 : $urandom_range(0, MAX_WAIT);
			end
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	// offer one request after a random gap and hold it until taken
	task automatic send_item(logic kind, logic [ID_W-1:0] index);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= kind;
		req.index <= index;
		do @(posedge clk); while (!req.ready);
		sent++;
	endtask

	// stop offering and wait for every outstanding response
	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (awaited_count != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(logic [CNT_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_writes++;
	endtask

	// acquires at the given percentage; releases mostly of ids in a window that is likely held, some anywhere
	task automatic run_phase(int items, int acquire_pct, int window);
		int n;
		for (n = 0; n < items; n++) begin
			if ($urandom_range(1, 100) <= acquire_pct)
				send_item(KIND_ACQUIRE, ID_W'($urandom));
			else if ($urandom_range(1, 100) <= 85)
				send_item(KIND_RELEASE, ID_W'($urandom_range(0, window - 1)));
			else
				send_item(KIND_RELEASE, ID_W'($urandom));
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.kind = KIND_ACQUIRE;
		req.index = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		quiet = 1'b0;
		hold_request = 1'b0;
		sent = 0;
		cap_writes = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: mint, reuse order, misses, top-entry release, empty table
		send_item(KIND_ACQUIRE, 8'd0);
		send_item(KIND_ACQUIRE, 8'd0);
		send_item(KIND_ACQUIRE, 8'd0);
		send_item(KIND_RELEASE, 8'd1);
		send_item(KIND_RELEASE, 8'd1);   // no longer held
		send_item(KIND_RELEASE, 8'd200); // never minted
		send_item(KIND_RELEASE, 8'd255);
		send_item(KIND_RELEASE, 8'd0);
		send_item(KIND_ACQUIRE, 8'd0);   // gets 0 back, newest release first
		send_item(KIND_ACQUIRE, 8'd0);   // then 1
		send_item(KIND_ACQUIRE, 8'd0);   // fresh id 3
		send_item(KIND_RELEASE, 8'd3);   // top entry itself
		send_item(KIND_ACQUIRE, 8'd255); // index ignored on acquire
		send_item(KIND_RELEASE, 8'd2);
		send_item(KIND_RELEASE, 8'd0);
		send_item(KIND_RELEASE, 8'd1);
		send_item(KIND_RELEASE, 8'd3);
		send_item(KIND_RELEASE, 8'd0);   // nothing held
		send_item(KIND_ACQUIRE, 8'd0);
		drain();

		// small capacity, receiver holds off for a long stretch at the start
		write_capacity(9'd12);
		hold_request = 1'b1;
		run_phase(150, 55, 16);
		drain();

		// capacity below the minted count: reuse only
		write_capacity(9'd0);
		run_phase(100, 50, 16);
		drain();

		// back-to-back traffic, then a full pause, then idling again
		write_capacity(9'd40);
		quiet = 1'b1;
		run_phase(60, 60, 48);
		drain();
		quiet = 1'b0;
		run_phase(60, 60, 48);
		drain();

		// capacity above the table size is clamped; fill the table completely
		write_capacity(9'd511);
		run_phase(300, 95, 256);
		drain();

		// drain back down with mostly releases
		write_capacity(CAPACITY_RST);
		run_phase(250, 35, 256);
		drain();
		repeat (20) @(posedge clk);

		$display("Run: %0d requests over %0d capacity settings, %0d responses checked.",
			sent, cap_writes + 1, checked_count);
		$display("Successful transactions: %0d, peak held ids: %0d.", ok_count, peak_held);
		if (fail_count == 0 && awaited_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
